// File: design/assert_macros.svh
// Assertion helpers included by block_average_window_max.
// Both macros sample on the rising edge of clock and are disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define BAWM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BAWM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/bawm_pkg.sv
// ----------------------------------------------------------------------------
// bawm_pkg
// Shared constants, register codes and control structs of the boxcar
// decimator with window peak.
// ----------------------------------------------------------------------------
package bawm_pkg;

   localparam int SAMPLE_BITS          = 12;
   localparam int INDEX_BITS           = 8;
   localparam int SPP_BITS             = 7;
   localparam int WP_BITS              = 9;
   localparam int CSR_INDEX_BITS       = 4;
   localparam int CSR_DATA_BITS        = 16;

   localparam int WINDOW_DEPTH_DEFAULT = 256;
   localparam int GROUP_MAX_DEFAULT    = 64;

   localparam logic [SPP_BITS-1:0]       SPP_RESET = 7'd40;
   localparam logic [WP_BITS-1:0]        WP_RESET  = 9'd256;
   localparam logic [SAMPLE_BITS-1:0]    SAMPLE_MAX = '1;

   localparam logic [CSR_INDEX_BITS-1:0] REG_SAMPLES_PER_POINT = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_WINDOW_POINTS     = 4'd1;

   typedef struct packed {
      logic wr_en;
      logic scan_start;
   } win_cmd_type;

   typedef struct packed {
      logic clearing;
      logic scan_done;
   } win_stat_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// File: design/bawm_channels.sv
// ----------------------------------------------------------------------------
// bawm channels
// Valid/ready channel bundles for samples, results and register writes.
// ----------------------------------------------------------------------------
interface bawm_req_if;
   import bawm_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface bawm_rsp_if;
   import bawm_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] point_value;
   logic [INDEX_BITS-1:0]  point_index;
   logic [SAMPLE_BITS-1:0] window_max;
   modport source (output valid, output point_value, output point_index,
                   output window_max, input ready);
   modport sink   (input valid, input point_value, input point_index,
                   input window_max, output ready);
endinterface

interface bawm_csr_if;
   import bawm_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/block_average_window_max.sv
// ----------------------------------------------------------------------------
// block_average_window_max
// Boxcar decimator: averages groups of samples into a window store and
// reports each new point with the peak of the window in use.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  req_if  | in        | sample
//  rsp_if  | out       | point_value, point_index, window_max
//  csr_if  | in        | index, data (samples_per_point, window_points)
//
// Samples that do not close a group are added to the running sum and can be
// taken back to back. A closing sample waits for the bit-serial divider and the
// one-entry-per-cycle scan over the window memory's read port; no new sample is
// taken until its result is loaded into the output register. After reset the
// window memory is cleared entry by entry, during which no sample is taken. A
// stalled result stays in the output register while the next group is gathered.
`include "assert_macros.svh"

module block_average_window_max #(
   parameter int WINDOW_DEPTH = bawm_pkg::WINDOW_DEPTH_DEFAULT,
   parameter int GROUP_MAX    = bawm_pkg::GROUP_MAX_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   bawm_req_if.sink   req_if,
   bawm_rsp_if.source rsp_if,
   bawm_csr_if.sink   csr_if
);
   import bawm_pkg::*;

   localparam int GLEN_W = $clog2(GROUP_MAX + 1);
   localparam int SUM_W  = SAMPLE_BITS + GLEN_W;
   localparam int POS_W  = $clog2(WINDOW_DEPTH);
   localparam int WLEN_W = $clog2(WINDOW_DEPTH + 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_PUSH = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [SPP_BITS-1:0]    spp_ff, spp_in;
   logic [WP_BITS-1:0]     wp_ff, wp_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [GLEN_W-1:0]      count_ff, count_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [SAMPLE_BITS-1:0] avg_ff, avg_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic [INDEX_BITS-1:0]  rsp_index_ff, rsp_index_in;
   logic [SAMPLE_BITS-1:0] rsp_max_ff, rsp_max_in;

   logic [GLEN_W-1:0]      glen;
   logic [WLEN_W-1:0]      wlen;
   logic [SUM_W-1:0]       sum_add;
   logic [GLEN_W:0]        count_add;
   logic                   group_done;
   logic [WLEN_W-1:0]      pos_inc;
   logic [POS_W-1:0]       pos_adv;
   logic                   req_ready;
   logic                   req_xfer;
   logic                   slot_free;
   logic                   div_start;
   logic [SUM_W-1:0]       quotient;
   logic [SAMPLE_BITS-1:0] avg_sat;
   div_stat_type           div_stat;
   win_cmd_type            win_cmd;
   win_stat_type           win_stat;
   logic [SAMPLE_BITS-1:0] peak;

   bawm_divider #(
      .GROUP_MAX (GROUP_MAX)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_add),
      .divisor  (glen),
      .quotient (quotient),
      .stat     (div_stat)
   );

   bawm_window #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .reset   (reset),
      .cmd     (win_cmd),
      .wr_addr (pos_ff),
      .wr_data (avg_sat),
      .wlen    (wlen),
      .stat    (win_stat),
      .peak    (peak)
   );

   // Effective lengths with the out-of-range register values folded in.
   always_comb begin
      if (spp_ff == '0) begin
         glen = GLEN_W'(1);
      end else if (32'(spp_ff) > 32'(GROUP_MAX)) begin
         glen = GLEN_W'(GROUP_MAX);
      end else begin
         glen = GLEN_W'(spp_ff);
      end
      if (wp_ff == '0) begin
         wlen = WLEN_W'(1);
      end else if (32'(wp_ff) > 32'(WINDOW_DEPTH)) begin
         wlen = WLEN_W'(WINDOW_DEPTH);
      end else begin
         wlen = WLEN_W'(wp_ff);
      end
   end

   always_comb begin
      sum_add    = sum_ff + SUM_W'(req_if.sample);
      count_add  = {1'b0, count_ff} + (GLEN_W+1)'(1);
      group_done = (count_add >= {1'b0, glen});
      pos_inc    = WLEN_W'(pos_ff) + WLEN_W'(1);
      pos_adv    = (pos_inc >= wlen) ? '0 : POS_W'(pos_inc);
      avg_sat    = (quotient > SUM_W'(SAMPLE_MAX)) ? SAMPLE_MAX
                                                   : quotient[SAMPLE_BITS-1:0];
      req_ready  = (state_ff == ST_IDLE) && !win_stat.clearing;
      req_xfer   = req_if.valid && req_ready;
      slot_free  = !rsp_valid_ff || rsp_if.ready;
   end

   always_comb begin
      spp_in = spp_ff;
      wp_in  = wp_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            REG_SAMPLES_PER_POINT: spp_in = csr_if.data[SPP_BITS-1:0];
            REG_WINDOW_POINTS:     wp_in  = csr_if.data[WP_BITS-1:0];
            default:               ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      avg_in       = avg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_value_in = rsp_value_ff;
      rsp_index_in = rsp_index_ff;
      rsp_max_in   = rsp_max_ff;
      div_start    = 1'b0;
      win_cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (group_done) begin
                  sum_in    = '0;
                  count_in  = '0;
                  pos_in    = pos_adv;
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  sum_in   = sum_add;
                  count_in = count_add[GLEN_W-1:0];
               end
            end
         end
         ST_DIV: begin
            // The point write and the scan start share a cycle; the first scan read comes in
            // the next cycle and sees the new point.
            if (div_stat.done) begin
               avg_in             = avg_sat;
               win_cmd.wr_en      = 1'b1;
               win_cmd.scan_start = 1'b1;
               state_in           = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (win_stat.scan_done) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = avg_ff;
               rsp_index_in = INDEX_BITS'(pos_ff);
               rsp_max_in   = peak;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         spp_ff       <= SPP_RESET;
         wp_ff        <= WP_RESET;
         sum_ff       <= '0;
         count_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         spp_ff       <= spp_in;
         wp_ff        <= wp_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      avg_ff       <= avg_in;
      rsp_value_ff <= rsp_value_in;
      rsp_index_ff <= rsp_index_in;
      rsp_max_ff   <= rsp_max_in;
   end

   assign req_if.ready       = req_ready;
   assign csr_if.ready       = 1'b1;
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.point_value = rsp_value_ff;
   assign rsp_if.point_index = rsp_index_ff;
   assign rsp_if.window_max  = rsp_max_ff;

   `BAWM_ASSERT_NOW(a_no_sample_while_clearing, req_if.valid && req_if.ready, !win_stat.clearing, "sample transfer during window clear")
   `BAWM_ASSERT_NOW(a_div_only_in_div, div_stat.busy || div_stat.done, state_ff == ST_DIV, "divider active outside the divide phase")
   `BAWM_ASSERT_NOW(a_scan_done_in_scan, win_stat.scan_done, state_ff == ST_SCAN, "scan finished outside the scan phase")
   `BAWM_ASSERT_NEXT(a_push_loads_result, (state_ff == ST_PUSH) && slot_free, rsp_valid_ff && (state_ff == ST_IDLE), "result not loaded after push")

endmodule

// File: design/bawm_divider.sv
// ----------------------------------------------------------------------------
// bawm_divider
// Restoring divider, one quotient bit per cycle, for the group average.
// ----------------------------------------------------------------------------
module bawm_divider #(
   parameter int GROUP_MAX = bawm_pkg::GROUP_MAX_DEFAULT
) (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  start,
   input  logic [bawm_pkg::SAMPLE_BITS+$clog2(GROUP_MAX+1)-1:0] dividend,
   input  logic [$clog2(GROUP_MAX+1)-1:0]                        divisor,
   output logic [bawm_pkg::SAMPLE_BITS+$clog2(GROUP_MAX+1)-1:0] quotient,
   output bawm_pkg::div_stat_type                                stat
);
   import bawm_pkg::*;

   localparam int DIV_W = $clog2(GROUP_MAX + 1);
   localparam int SUM_W = SAMPLE_BITS + DIV_W;
   localparam int CNT_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [DIV_W:0]   rem_shift;
   logic [DIV_W:0]   rem_diff;
   logic             fits;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[SUM_W-1]};
      rem_diff  = rem_shift - {1'b0, dvs_ff};
      fits      = (rem_shift >= {1'b0, dvs_ff});
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CNT_W'(SUM_W);
      end else if (cnt_ff != '0) begin
         // The dividend shifts out of the top while quotient bits shift in below.
         quo_in  = {quo_ff[SUM_W-2:0], fits};
         rem_in  = fits ? rem_diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = (cnt_ff != '0);
   assign stat.done = done_ff;

endmodule

// File: design/bawm_window.sv
// ----------------------------------------------------------------------------
// bawm_window
// Window store with its clearing pass after reset, point writes and a
// sequential peak scan over the entries in use.
// ----------------------------------------------------------------------------
module bawm_window #(
   parameter int WINDOW_DEPTH = bawm_pkg::WINDOW_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  bawm_pkg::win_cmd_type                 cmd,
   input  logic [$clog2(WINDOW_DEPTH)-1:0]       wr_addr,
   input  logic [bawm_pkg::SAMPLE_BITS-1:0]      wr_data,
   input  logic [$clog2(WINDOW_DEPTH+1)-1:0]     wlen,
   output bawm_pkg::win_stat_type                stat,
   output logic [bawm_pkg::SAMPLE_BITS-1:0]      peak
);
   import bawm_pkg::*;

   localparam int POS_W  = $clog2(WINDOW_DEPTH);
   localparam int WLEN_W = $clog2(WINDOW_DEPTH + 1);

   logic [SAMPLE_BITS-1:0] mem_array [WINDOW_DEPTH];

   logic                   clear_ff, clear_in;
   logic [POS_W-1:0]       clear_cnt_ff, clear_cnt_in;
   logic                   scanning_ff, scanning_in;
   logic [WLEN_W-1:0]      idx_ff, idx_in;
   logic                   issue_ff, issue_in;
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic [SAMPLE_BITS-1:0] peak_ff, peak_in;
   logic                   rd_en;
   logic                   scan_done;

   always_comb begin
      clear_in     = clear_ff;
      clear_cnt_in = clear_cnt_ff;
      if (clear_ff) begin
         clear_cnt_in = clear_cnt_ff + POS_W'(1);
         if (clear_cnt_ff == POS_W'(WINDOW_DEPTH - 1)) begin
            clear_in = 1'b0;
         end
      end

      rd_en     = scanning_ff && (idx_ff < wlen);
      // The scan ends once every read has been issued and the last one compared.
      scan_done = scanning_ff && !rd_en && !issue_ff;
      issue_in  = rd_en;

      scanning_in = scanning_ff;
      idx_in      = idx_ff;
      peak_in     = peak_ff;
      if (cmd.scan_start) begin
         scanning_in = 1'b1;
         idx_in      = '0;
         peak_in     = '0;
      end else begin
         if (scan_done) begin
            scanning_in = 1'b0;
         end
         if (rd_en) begin
            idx_in = idx_ff + WLEN_W'(1);
         end
         if (issue_ff && (rd_data_ff > peak_ff)) begin
            peak_in = rd_data_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clear_cnt_ff <= '0;
         scanning_ff  <= 1'b0;
         issue_ff     <= 1'b0;
      end else begin
         clear_ff     <= clear_in;
         clear_cnt_ff <= clear_cnt_in;
         scanning_ff  <= scanning_in;
         issue_ff     <= issue_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      peak_ff <= peak_in;
   end

   // Single write port shared by the clearing pass and point writes.
   always_ff @(posedge clock) begin
      if (clear_ff) begin
         mem_array[clear_cnt_ff] <= '0;
      end else if (cmd.wr_en) begin
         mem_array[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_array[idx_ff[POS_W-1:0]];
      end
   end

   assign stat.clearing  = clear_ff;
   assign stat.scan_done = scan_done;
   assign peak           = peak_ff;

endmodule
